[design/usv_pkg.sv]
// Package of the UV sphere vertex generator: item types, pipeline depths,
// CORDIC arctangent table and fixed-point constants.
// Depends on nothing; all design files refer to it by scoped names.
package usv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int SUB_W = 8;
	localparam logic [SUB_W-1:0] SUBDIV_RESET = 8'd16;

	localparam int DIV_STEPS = 33;
	localparam int DVS_W = SUB_W + 1;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;
	localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

	localparam logic signed [CW-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
		34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608,
		34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41, 34'sd20,
		34'sd10, 34'sd5, 34'sd3, 34'sd1
	};

	localparam int DIV_END = 1 + DIV_STEPS;
	localparam int COR_END = DIV_END + CORDIC_LAT;
	localparam int MUL_STG = COR_END + 1;

	localparam int PROD_SHIFT = 60 - FRAC_BITS;
	localparam int COS_SHIFT = 30 - FRAC_BITS;
	localparam logic signed [63:0] PROD_HALF = 64'sd1 <<< (PROD_SHIFT - 1);
	localparam logic signed [31:0] COS_HALF = 32'sd1 <<< (COS_SHIFT - 1);
	localparam logic signed [63:0] POS_LIM = 64'sd1 <<< FRAC_BITS;

	typedef struct packed {
		logic [7:0] ring;
		logic [7:0] sector;
	} pt_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] vertex_index;
		logic quad_valid;
		logic [15:0] corner_right;
		logic [15:0] corner_below;
		logic [15:0] corner_diag;
		logic in_range;
	} vtx_t;

	typedef struct packed {
		logic [15:0] vertex_index;
		logic quad_valid;
		logic [15:0] corner_right;
		logic [15:0] corner_below;
		logic [15:0] corner_diag;
		logic in_range;
	} side_t;

	function automatic logic signed [15:0] sat_pos(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v > POS_LIM) begin
			c = POS_LIM;
		end else if (v < -POS_LIM) begin
			c = -POS_LIM;
		end
		return c[15:0];
	endfunction

endpackage

[design/usv_div.sv]
// Pipelined restoring divider, one quotient bit per stage, 33 stages.
// Depends on usv_pkg for the step count and divisor width.
module usv_div (
	input  logic clk,
	input  logic en,
	input  logic [usv_pkg::DVS_W-1:0] rem_init,
	input  logic [usv_pkg::DIV_STEPS-1:0] num_init,
	input  logic [usv_pkg::DVS_W-1:0] divisor,
	output logic [usv_pkg::DIV_STEPS-1:0] quo
);

	localparam int N = usv_pkg::DIV_STEPS;
	localparam int DW = usv_pkg::DVS_W;

	logic [DW-1:0] rem_s [N+1];
	logic [N-1:0] num_s [N+1];

	assign rem_s[0] = rem_init;
	assign num_s[0] = num_init;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [DW:0] trial;
		logic ge;
		assign trial = {rem_s[k], num_s[k][N-1]};
		assign ge = trial >= {1'b0, divisor};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
				num_s[k+1] <= {num_s[k][N-2:0], ge};
			end
		end
	end

	assign quo = num_s[N];

endmodule

[design/usv_cordic.sv]
// Pipelined rotation CORDIC: quadrant fold, 30 rotation stages, sign and clamp.
// Depends on usv_pkg for the arctangent table and Q2.30 constants.
module usv_cordic (
	input  logic clk,
	input  logic en,
	input  logic [31:0] phase,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);

	localparam int N = usv_pkg::CORDIC_STEPS;
	localparam int W = usv_pkg::CW;

	logic signed [W-1:0] x_s [N+1];
	logic signed [W-1:0] y_s [N+1];
	logic signed [W-1:0] z_s [N+1];
	logic neg_s [N+1];
	logic signed [W-1:0] z_in;
	logic signed [W-1:0] xf;
	logic signed [W-1:0] yf;

	assign z_in = W'(signed'(phase));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= usv_pkg::CORDIC_X0;
			y_s[0] <= '0;
			if (z_in > usv_pkg::QUARTER_TURN) begin
				z_s[0] <= z_in - usv_pkg::HALF_TURN;
				neg_s[0] <= 1'b1;
			end else if (z_in < -usv_pkg::QUARTER_TURN) begin
				z_s[0] <= z_in + usv_pkg::HALF_TURN;
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0] <= z_in;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_s[k];
				if (z_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - usv_pkg::CORDIC_ATAN[k];
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + usv_pkg::CORDIC_ATAN[k];
				end
			end
		end
	end

	assign xf = neg_s[N] ? -x_s[N] : x_s[N];
	assign yf = neg_s[N] ? -y_s[N] : y_s[N];

	always_ff @(posedge clk) begin
		if (en) begin
			if (xf > usv_pkg::ONE_Q30) begin
				cos_v <= 32'(usv_pkg::ONE_Q30);
			end else if (xf < -usv_pkg::ONE_Q30) begin
				cos_v <= 32'(-usv_pkg::ONE_Q30);
			end else begin
				cos_v <= xf[31:0];
			end
			if (yf > usv_pkg::ONE_Q30) begin
				sin_v <= 32'(usv_pkg::ONE_Q30);
			end else if (yf < -usv_pkg::ONE_Q30) begin
				sin_v <= 32'(-usv_pkg::ONE_Q30);
			end else begin
				sin_v <= yf[31:0];
			end
		end
	end

endmodule

[design/uv_sphere_vertex_generator_unit.sv]
// Top level of the UV sphere vertex generator: input stage, angle and texture
// dividers, two CORDIC units, product and rounding stages, output register.
// Depends on usv_pkg, usv_div and usv_cordic.
// Accepts one item per cycle while the output is not stalled.
// Depth: input register, 33-stage divider, 32-stage CORDIC, product and output registers.
// Reset clears all valid bits and sets subdivisions to 16.
module uv_sphere_vertex_generator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [usv_pkg::SUB_W-1:0] cfg_data,
	input  logic pt_valid,
	output logic pt_stall,
	input  usv_pkg::pt_t pt,
	output logic vtx_valid,
	input  logic vtx_stall,
	output usv_pkg::vtx_t vtx
);

	localparam int DE = usv_pkg::DIV_END;
	localparam int MS = usv_pkg::MUL_STG;
	localparam int DN = usv_pkg::DIV_STEPS;
	localparam int DW = usv_pkg::DVS_W;

	logic [usv_pkg::SUB_W-1:0] subdiv_q;
	logic [usv_pkg::SUB_W-1:0] s_eff;
	logic en;
	logic vld_s [1:MS];
	usv_pkg::pt_t pt_s1;
	usv_pkg::side_t side_c;
	usv_pkg::side_t side_s [2:MS];
	logic [15:0] tex_u_s [DE+1:MS];
	logic [15:0] tex_v_s [DE+1:MS];
	logic [DN-1:0] q_pp, q_pa, q_tu, q_tv;
	logic signed [31:0] cp, sp, ca, sa;
	logic signed [63:0] prod_x_s67, prod_z_s67;
	logic signed [31:0] cp_s67;
	logic signed [63:0] rx, rz, ry;
	logic [15:0] idx1;
	usv_pkg::vtx_t vtx_q;
	logic vtx_valid_q;

	assign cfg_ready = 1'b1;
	assign s_eff = (subdiv_q == '0) ? 8'd1 : subdiv_q;
	assign en = !(vtx_valid_q && vtx_stall);
	assign pt_stall = !en;
	assign vtx_valid = vtx_valid_q;
	assign vtx = vtx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= usv_pkg::SUBDIV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			subdiv_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= MS; i++) begin
				vld_s[i] <= 1'b0;
			end
			vtx_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[1] <= pt_valid;
			for (int i = 2; i <= MS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vtx_valid_q <= vld_s[MS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= pt;
		end
	end

	assign idx1 = 16'(pt_s1.ring) * 16'({1'b0, s_eff} + 9'd1) + 16'(pt_s1.sector);

	always_comb begin
		side_c.in_range = (pt_s1.ring <= s_eff) && (pt_s1.sector <= s_eff);
		side_c.quad_valid = (pt_s1.ring < s_eff) && (pt_s1.sector < s_eff);
		side_c.vertex_index = idx1;
		side_c.corner_right = side_c.quad_valid ? idx1 + 16'd1 : '0;
		side_c.corner_below = side_c.quad_valid ? idx1 + 16'(s_eff) + 16'd1 : '0;
		side_c.corner_diag = side_c.quad_valid ? idx1 + 16'(s_eff) + 16'd2 : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[2] <= side_c;
			for (int i = 3; i <= MS; i++) begin
				side_s[i] <= side_s[i-1];
			end
			tex_u_s[DE+1] <= q_tu[15:0];
			tex_v_s[DE+1] <= q_tv[15:0];
			for (int i = DE + 2; i <= MS; i++) begin
				tex_u_s[i] <= tex_u_s[i-1];
				tex_v_s[i] <= tex_v_s[i-1];
			end
		end
	end

	usv_div u_div_pp (
		.clk(clk), .en(en),
		.rem_init(DW'(pt_s1.ring >> 1)),
		.num_init({pt_s1.ring[0], 32'(s_eff)}),
		.divisor({s_eff, 1'b0}),
		.quo(q_pp)
	);

	usv_div u_div_pa (
		.clk(clk), .en(en),
		.rem_init(DW'(pt_s1.sector >> 1)),
		.num_init({pt_s1.sector[0], 32'(s_eff >> 1)}),
		.divisor({1'b0, s_eff}),
		.quo(q_pa)
	);

	usv_div u_div_tu (
		.clk(clk), .en(en),
		.rem_init('0),
		.num_init(DN'({pt_s1.sector, 15'd0}) + DN'(s_eff >> 1)),
		.divisor({1'b0, s_eff}),
		.quo(q_tu)
	);

	usv_div u_div_tv (
		.clk(clk), .en(en),
		.rem_init('0),
		.num_init(DN'({pt_s1.ring, 15'd0}) + DN'(s_eff >> 1)),
		.divisor({1'b0, s_eff}),
		.quo(q_tv)
	);

	usv_cordic u_cor_polar (
		.clk(clk), .en(en), .phase(q_pp[31:0]), .cos_v(cp), .sin_v(sp)
	);

	usv_cordic u_cor_az (
		.clk(clk), .en(en), .phase(q_pa[31:0]), .cos_v(ca), .sin_v(sa)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s67 <= sp * ca;
			prod_z_s67 <= sp * sa;
			cp_s67 <= cp;
		end
	end

	assign rx = (prod_x_s67 + usv_pkg::PROD_HALF) >>> usv_pkg::PROD_SHIFT;
	assign rz = (prod_z_s67 + usv_pkg::PROD_HALF) >>> usv_pkg::PROD_SHIFT;
	assign ry = 64'((cp_s67 + usv_pkg::COS_HALF) >>> usv_pkg::COS_SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[MS].in_range) begin
				vtx_q.pos_x <= usv_pkg::sat_pos(rx);
				vtx_q.pos_y <= usv_pkg::sat_pos(ry);
				vtx_q.pos_z <= usv_pkg::sat_pos(rz);
				vtx_q.tex_u <= tex_u_s[MS];
				vtx_q.tex_v <= tex_v_s[MS];
				vtx_q.vertex_index <= side_s[MS].vertex_index;
				vtx_q.quad_valid <= side_s[MS].quad_valid;
				vtx_q.corner_right <= side_s[MS].corner_right;
				vtx_q.corner_below <= side_s[MS].corner_below;
				vtx_q.corner_diag <= side_s[MS].corner_diag;
				vtx_q.in_range <= 1'b1;
			end else begin
				vtx_q <= '0;
			end
		end
	end

	// An out-of-range item carries nothing but zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx.in_range |-> vtx.vertex_index == '0 && vtx.tex_u == '0 &&
		vtx.pos_x == '0 && vtx.pos_y == '0 && vtx.quad_valid == 1'b0)
		else $error("out-of-range item has nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx.quad_valid |-> vtx.in_range &&
		vtx.corner_right == vtx.vertex_index + 16'd1 &&
		vtx.corner_diag == vtx.corner_below + 16'd1)
		else $error("quad corners inconsistent");

	assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx.in_range |-> vtx.tex_u <= 16'd32768 && vtx.tex_v <= 16'd32768)
		else $error("texture coordinate above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx.in_range |->
		vtx.pos_y <= 16'sd16384 && vtx.pos_y >= -16'sd16384)
		else $error("pos_y outside unit range");

endmodule
